[hw/rtl/uea_pkg.sv]
package uea_pkg;

    // Table size and derived widths
    localparam int NUM_LOGICAL = 8;
    localparam int LG_W        = (NUM_LOGICAL > 1) ? $clog2(NUM_LOGICAL) : 1;
    localparam int MASK_W      = 2 * NUM_LOGICAL;
    localparam int ATTR_W      = 6 * NUM_LOGICAL;
    localparam int COSTS_W     = 8 * NUM_LOGICAL;

    localparam int COST_W      = 24;
    localparam int SIZE_W      = 10;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 2;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 40;

    localparam logic [7:0] IN_FLAG = 8'h80;

    // Request opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_PAIR  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Direction codes of an entry
    localparam logic [1:0] DIR_BOTH   = 2'd0;
    localparam logic [1:0] DIR_IN     = 2'd1;
    localparam logic [1:0] DIR_OUT    = 2'd2;
    localparam logic [1:0] DIR_SHARED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ATTR  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BYTE  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COST,
        ST_OUT
    } state_t;

endpackage

[hw/rtl/usb_endpoint_allocator.sv]
// USB endpoint allocator.
// Requests arrive on the s_axis channel (opcode in tuser), results leave on
// m_axis; tlast marks the final result of a request. Configuration is a
// plain write port (cfg_we, cfg_addr, cfg_data). The user must write it
// only while idle; the block itself does not enforce this. An allocate
// request walks the endpoint table one entry per cycle through a single
// match unit, then on a hit passes through the cost adder (base plus byte
// cost times packet size, saturating). A control pair runs two such
// searches back to back, the second starting once the first result is
// taken. Clear and unused opcodes go straight to the output register.
// Throughput is one request at a time: s_axis_tready is low from accept
// until the last result of that request is taken.
// The result sits in the output register until m_axis_tready; a stalled
// receiver simply holds the block busy, nothing is dropped.
// Reset empties the used mask, zeroes the total cost, sets the success
// flag and clears all configuration registers.
module usb_endpoint_allocator
(
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_we,
    input  logic [uea_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [uea_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] direction_in, [2:1] ep_type, [12:3] packet_size, [15:13] zero
    input  logic [uea_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                        s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] endpoint_address, [8] found, [9] config_valid,
    // [33:10] total_cost, [39:34] zero
    output logic [uea_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic                              m_axis_tlast
);

    // configuration registers
    logic [uea_pkg::ATTR_W-1:0]   attr_reg;
    logic [uea_pkg::COSTS_W-1:0]  base_reg;
    logic [uea_pkg::COSTS_W-1:0]  per_reg;
    logic [uea_pkg::COST_W-1:0]   limit_reg;

    // allocator state
    uea_pkg::state_t              state_reg, state_next;
    logic [uea_pkg::MASK_W-1:0]   used_reg, used_next;
    logic [uea_pkg::COST_W-1:0]   cost_reg, cost_next;
    logic                         ok_reg, ok_next;
    logic [uea_pkg::LG_W-1:0]     lg_reg, lg_next;
    logic                         pair_reg, pair_next;
    logic                         found_reg, found_next;

    // request and result payload
    logic                         dir_reg, dir_next;
    logic [1:0]                   type_reg, type_next;
    logic [uea_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [7:0]                   addr_reg, addr_next;

    // shared match unit and cost adder
    logic [5:0]                   attr_cur;
    logic [1:0]                   dcode;
    logic [uea_pkg::LG_W:0]       self_idx;
    logic [uea_pkg::LG_W:0]       other_idx;
    logic                         match;
    logic                         last_entry;
    logic [7:0]                   base_cur;
    logic [7:0]                   per_cur;
    logic [17:0]                  prod;
    logic [uea_pkg::COST_W:0]     sum;
    logic                         s_fire;
    logic                         m_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // check the entry under the scan pointer
    always_comb
    begin
        attr_cur   = attr_reg[6*lg_reg +: 6];
        dcode      = attr_cur[5:4];
        self_idx   = {lg_reg, dir_reg};
        other_idx  = {lg_reg, ~dir_reg};
        match      = attr_cur[type_reg]
                     && !(dir_reg && dcode == uea_pkg::DIR_OUT)
                     && !(!dir_reg && dcode == uea_pkg::DIR_IN)
                     && !used_reg[self_idx]
                     && !(dcode == uea_pkg::DIR_SHARED && used_reg[other_idx]);
        last_entry = (lg_reg == uea_pkg::LG_W'(uea_pkg::NUM_LOGICAL - 1));
        base_cur   = base_reg[8*lg_reg +: 8];
        per_cur    = per_reg[8*lg_reg +: 8];
        prod       = 18'(per_cur) * 18'(size_reg);
        sum        = {1'b0, cost_reg} + 25'(base_cur) + 25'(prod);
    end

    // sequencer: next state and outputs
    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        cost_next  = cost_reg;
        ok_next    = ok_reg;
        lg_next    = lg_reg;
        pair_next  = pair_reg;
        found_next = found_reg;
        dir_next   = dir_reg;
        type_next  = type_reg;
        size_next  = size_reg;
        addr_next  = addr_reg;

        case (state_reg)
            uea_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    dir_next   = s_axis_tdata[0];
                    type_next  = s_axis_tdata[2:1];
                    size_next  = s_axis_tdata[12:3];
                    lg_next    = '0;
                    pair_next  = 1'b0;
                    found_next = 1'b0;
                    addr_next  = '0;
                    case (s_axis_tuser)
                        uea_pkg::OP_ALLOC:
                        begin
                            state_next = uea_pkg::ST_SCAN;
                        end
                        uea_pkg::OP_PAIR:
                        begin
                            dir_next   = 1'b1;
                            type_next  = 2'd0;
                            pair_next  = 1'b1;
                            state_next = uea_pkg::ST_SCAN;
                        end
                        uea_pkg::OP_CLEAR:
                        begin
                            used_next  = '0;
                            cost_next  = '0;
                            ok_next    = 1'b1;
                            state_next = uea_pkg::ST_OUT;
                        end
                        default:
                        begin
                            state_next = uea_pkg::ST_OUT;
                        end
                    endcase
                end
            end

            uea_pkg::ST_SCAN:
            begin
                // stop on a hit, advance otherwise, fail past the end
                if (match)
                begin
                    state_next = uea_pkg::ST_COST;
                end
                else if (last_entry)
                begin
                    ok_next    = 1'b0;
                    found_next = 1'b0;
                    addr_next  = '0;
                    state_next = uea_pkg::ST_OUT;
                end
                else
                begin
                    lg_next = lg_reg + 1'b1;
                end
            end

            uea_pkg::ST_COST:
            begin
                // add cost with saturation and mark the endpoint used
                cost_next  = sum[uea_pkg::COST_W] ? '1 : sum[uea_pkg::COST_W-1:0];
                used_next  = used_reg | (uea_pkg::MASK_W'(1) << self_idx);
                found_next = 1'b1;
                addr_next  = 8'(lg_reg) | (dir_reg ? uea_pkg::IN_FLAG : 8'h00);
                state_next = uea_pkg::ST_OUT;
            end

            uea_pkg::ST_OUT:
            begin
                // hold the word until taken, then run the OUT half of a pair
                if (m_fire)
                begin
                    if (pair_reg)
                    begin
                        pair_next  = 1'b0;
                        dir_next   = 1'b0;
                        lg_next    = '0;
                        state_next = uea_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = uea_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = uea_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == uea_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == uea_pkg::ST_OUT);
    assign m_axis_tlast  = !pair_reg;
    assign m_axis_tdata  = {6'd0, cost_reg,
                            ok_reg && (cost_reg <= limit_reg),
                            found_reg, addr_reg};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uea_pkg::ST_IDLE;
            used_reg  <= '0;
            cost_reg  <= '0;
            ok_reg    <= 1'b1;
            lg_reg    <= '0;
            pair_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            cost_reg  <= cost_next;
            ok_reg    <= ok_next;
            lg_reg    <= lg_next;
            pair_reg  <= pair_next;
            found_reg <= found_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        dir_reg  <= dir_next;
        type_reg <= type_next;
        size_reg <= size_next;
        addr_reg <= addr_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg  <= '0;
            base_reg  <= '0;
            per_reg   <= '0;
            limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                uea_pkg::REG_ATTR:  attr_reg  <= cfg_data[uea_pkg::ATTR_W-1:0];
                uea_pkg::REG_BASE:  base_reg  <= cfg_data[uea_pkg::COSTS_W-1:0];
                uea_pkg::REG_BYTE:  per_reg   <= cfg_data[uea_pkg::COSTS_W-1:0];
                uea_pkg::REG_LIMIT: limit_reg <= cfg_data[uea_pkg::COST_W-1:0];
                default:            limit_reg <= limit_reg;
            endcase
        end
    end

    // checks
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while a result is pending");

    a_hit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uea_pkg::ST_COST) |-> !used_reg[self_idx])
        else $error("endpoint allocated twice");

    a_cost_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uea_pkg::ST_COST) |=> (m_axis_tvalid && m_axis_tdata[8]))
        else $error("hit did not produce a found result");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("miss result carries an address");

endmodule
